@@ design/sem_pkg.sv @@
// Shared constants and types for the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;

  localparam int unsigned CfgW         = 12;
  localparam int unsigned PixW         = 8;
  localparam int unsigned CfgIdxW      = 4;
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned HeightCap    = 2048;
  localparam int unsigned ResetWidth   = 640;
  localparam int unsigned ResetHeight  = 480;
  localparam int unsigned RootSat      = 65280;

  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = CfgIdxW'(1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // one window column, [0] = top row
  typedef logic [2:0][PixW-1:0] col_t;

endpackage

@@ design/sobel_edge_magnitude_top.sv @@
// Sobel gradient magnitude over a raster pixel stream, min-combined with a prior value.
// Depends on sem_pkg.
//
// An item that releases no result ends after the line store read; one that does
// then goes on through the gradients, the squares, the sum, the bit-wise rounded
// square root and the load of the output register, which waits while a held result
// is stalled. The line store (one port, MAX_WIDTH words of two pixels) is read
// on acceptance and written back the next cycle; one item is in flight at a time.
// The result for pixel i leaves with item i+width+1; width+1 flush words after the
// last pixel release the tail. A width or height write abandons the frame in progress.
module sobel_edge_magnitude_top #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MaxWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic [sem_pkg::PixW-1:0]   pixel_i,
  input  logic [sem_pkg::PixW-1:0]   prior_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sem_pkg::PixW-1:0]   edge_value_o,
  output logic                       frame_end_o,
  input  logic                       cfg_we_i,
  input  logic [sem_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sem_pkg::CfgW-1:0]   cfg_data_i
);
  import sem_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = CfgW;
  localparam int unsigned PendW = CfgW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [CfgW-1:0] fw_q, fh_q;
  logic [CfgW-1:0] eff_w, eff_h;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [PendW-1:0] pend_q, pend_d;

  // item registers
  logic [ColW-1:0] x_q;
  logic            ytwo_q, flush_q, emit_q, last_q;
  logic [PixW-1:0] pix_q, prior_q;

  logic [2*PixW-1:0] mem [MAX_WIDTH];
  logic [2*PixW-1:0] rdata_q;

  col_t win_q [3];
  logic signed [10:0] gx_q, gy_q;
  logic [19:0] sqx_q, sqy_q;
  logic [20:0] g_q;
  logic        sat_q;
  logic [7:0]  root_q;
  logic [2:0]  bit_q;

  logic [PixW-1:0] edge_q;
  logic            fend_q, oval_q;

  logic accept, flush, act, clr, emit, last, rd_en;
  logic [ColW-1:0] x;
  logic [RowW-1:0] y;
  logic [CfgW:0]   nx;

  always_comb begin
    eff_w = fw_q;
    if (fw_q == '0) eff_w = CfgW'(1);
    else if (32'(fw_q) > MAX_WIDTH) eff_w = CfgW'(MAX_WIDTH);
    eff_h = fh_q;
    if (fh_q == '0) eff_h = CfgW'(1);
    else if (32'(fh_q) > HeightCap) eff_h = CfgW'(HeightCap);
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    flush  = (op_i == OP_FLUSH);
    act    = !flush || (pend_q != '0);
    clr    = !flush && ((pend_q != '0) || (row_q >= eff_h) ||
                        ((CfgW+1)'(col_q) >= (CfgW+1)'(eff_w)));
    x      = clr ? '0 : col_q;
    y      = clr ? '0 : row_q;
    emit   = (x == '0) ? (y >= RowW'(2)) : (y >= RowW'(1));
    last   = (x == '0) && ((RowW+1)'(y) == (RowW+1)'(eff_h) + (RowW+1)'(1));
    nx     = (CfgW+1)'(x) + (CfgW+1)'(1);
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    rd_en  = accept && act;
    if (rd_en) begin
      if (nx >= (CfgW+1)'(eff_w)) begin
        col_d = '0;
        row_d = y + RowW'(1);
      end else begin
        col_d = nx[ColW-1:0];
        row_d = y;
      end
      if (flush) begin
        pend_d = pend_q - PendW'(1);
        if (pend_d == '0) begin
          col_d = '0;
          row_d = '0;
        end
      end else if (col_d == '0 && row_d == eff_h) begin
        pend_d = PendW'(eff_w) + PendW'(1);
      end else begin
        pend_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= CfgW'(ResetWidth);
      fh_q   <= CfgW'(ResetHeight);
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          fw_q   <= cfg_data_i;
          col_q  <= '0;
          row_q  <= '0;
          pend_q <= '0;
        end
        REG_FRAME_HEIGHT: begin
          fh_q   <= cfg_data_i;
          col_q  <= '0;
          row_q  <= '0;
          pend_q <= '0;
        end
        default: begin
          col_q  <= col_d;
          row_q  <= row_d;
          pend_q <= pend_d;
        end
      endcase
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      x_q     <= x;
      ytwo_q  <= (y >= RowW'(2));
      flush_q <= flush;
      emit_q  <= emit;
      last_q  <= last;
      pix_q   <= pixel_i;
      prior_q <= prior_value_i;
    end
  end

  // line store: word = {two lines back, one line back}
  logic [PixW-1:0] upper, middle;
  col_t            newcol;
  assign upper  = rdata_q[2*PixW-1:PixW];
  assign middle = rdata_q[PixW-1:0];
  always_comb begin
    newcol[0] = ytwo_q ? upper : middle;
    newcol[1] = middle;
    newcol[2] = flush_q ? middle : pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD && !flush_q) mem[x_q] <= {middle, pix_q};
    if (rd_en) rdata_q <= mem[x];
  end

  // gradient operands
  col_t opl, opc, opr;
  logic [9:0] sxl, sxr, syt, syb;
  always_comb begin
    if (x_q == '0) begin
      opl = win_q[1];
      opc = win_q[2];
      opr = win_q[2];
    end else begin
      opl = win_q[1];
      opc = win_q[2];
      opr = newcol;
    end
    sxl = 10'(opl[0]) + {1'b0, opl[1], 1'b0} + 10'(opl[2]);
    sxr = 10'(opr[0]) + {1'b0, opr[1], 1'b0} + 10'(opr[2]);
    syt = 10'(opl[0]) + {1'b0, opc[0], 1'b0} + 10'(opr[0]);
    syb = 10'(opl[2]) + {1'b0, opc[2], 1'b0} + 10'(opr[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) win_q[i] <= '0;
    end else if (state_q == S_RD) begin
      if (x_q == '0) begin
        for (int i = 0; i < 3; i++) win_q[i] <= newcol;
      end else begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= newcol;
      end
    end
  end

  logic signed [21:0] px, py;
  logic [7:0]  trial;
  logic [15:0] tprod;
  assign px    = 22'(gx_q) * 22'(gx_q);
  assign py    = 22'(gy_q) * 22'(gy_q);
  assign trial = root_q | (8'd1 << bit_q);
  assign tprod = 16'(trial) * (16'(trial) - 16'd1);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_RD: begin
        gx_q <= $signed({1'b0, sxr}) - $signed({1'b0, sxl});
        gy_q <= $signed({1'b0, syt}) - $signed({1'b0, syb});
      end
      S_SQ: begin
        sqx_q <= px[19:0];
        sqy_q <= py[19:0];
      end
      S_SUM: begin
        g_q    <= 21'(sqx_q) + 21'(sqy_q);
        sat_q  <= (21'(sqx_q) + 21'(sqy_q)) > 21'(RootSat);
        root_q <= '0;
        bit_q  <= 3'd7;
      end
      S_ROOT: begin
        if (21'(tprod) < g_q) root_q <= trial;
        bit_q <= bit_q - 3'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (rd_en) state_d = S_RD;
      S_RD:   state_d = emit_q ? S_SQ : S_IDLE;
      S_SQ:   state_d = S_SUM;
      S_SUM:  state_d = S_ROOT;
      S_ROOT: if (bit_q == 3'd0) state_d = S_OUT;
      S_OUT:  if (!oval_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [7:0] mag;
  assign mag = sat_q ? 8'hFF : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && (!oval_q || !out_stall_i)) oval_q <= 1'b1;
      else if (oval_q && !out_stall_i) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!oval_q || !out_stall_i)) begin
      edge_q <= (mag < prior_q) ? mag : prior_q;
      fend_q <= last_q;
    end
  end

  assign out_valid_o  = oval_q;
  assign edge_value_o = edge_q;
  assign frame_end_o  = fend_q;

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CfgW+1)'(col_q) < (CfgW+1)'(eff_w))
    else $error("column position beyond line width");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(eff_w) + PendW'(1))
    else $error("pending count above width+1");

  a_rd_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |=> state_q == S_IDLE || state_q == S_SQ)
    else $error("bad step after line store read");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result word without root pass");

endmodule

@@ tb/sv/sem_edge_checker.sv @@
// Checker for sobel_edge_magnitude_top: predicts edge words from accepted input
// words and config writes, and compares them with the accepted output words.
// Depends on sem_pkg.
`timescale 1ns / 100ps
module sem_edge_checker
  import sem_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               op_i,
  input  logic [PixW-1:0]    pixel_i,
  input  logic [PixW-1:0]    prior_value_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [PixW-1:0]    edge_value_o,
  input  logic               frame_end_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 errors_o,
  output int                 outstanding_o
);

  localparam int unsigned LineLen = MaxWidthDef;

  typedef struct packed {
    logic [PixW-1:0] edge_val;
    logic            frame_end;
  } edge_word_t;

  edge_word_t      edge_q[$];
  logic [PixW-1:0] line_up[LineLen];
  logic [PixW-1:0] line_mid[LineLen];
  col_t            win[3];
  logic [CfgW-1:0] width_reg, height_reg;
  int unsigned     col_n, row_n, owed;
  int              errs;

  function automatic int unsigned clamp_dim(logic [CfgW-1:0] v, int unsigned cap);
    if (v == 0) return 1;
    if (32'(v) > cap) return cap;
    return 32'(v);
  endfunction

  function automatic int unsigned edge_mag(col_t l, col_t m, col_t r);
    int gx, gy, g, n;
    gx = (r[0] + 2 * r[1] + r[2]) - (l[0] + 2 * l[1] + l[2]);
    gy = (l[0] + 2 * m[0] + r[0]) - (l[2] + 2 * m[2] + r[2]);
    g = gx * gx + gy * gy;
    n = 0;
    while (n < 255 && (n + 1) * n < g) n++;
    return n;
  endfunction

  task automatic clear_frame();
    col_n = 0;
    row_n = 0;
    owed = 0;
  endtask

  task automatic predict_word(logic flush, logic [PixW-1:0] pix, logic [PixW-1:0] prior);
    int unsigned w, h, x, y, mag;
    col_t        c;
    logic        emit, last;
    edge_word_t  e;
    w = clamp_dim(width_reg, LineLen);
    h = clamp_dim(height_reg, HeightCap);
    emit = 1'b0;
    last = 1'b0;
    mag = 0;
    if (flush) begin
      if (owed == 0) return;
    end else if (owed != 0 || row_n >= h || col_n >= w) begin
      clear_frame();
    end
    x = col_n % LineLen;
    y = row_n;
    c[0] = (y >= 2) ? line_up[x] : line_mid[x];
    c[1] = line_mid[x];
    c[2] = flush ? line_mid[x] : pix;
    if (!flush) begin
      line_up[x] = line_mid[x];
      line_mid[x] = pix;
    end
    if (x == 0) begin
      if (y >= 2) begin
        mag = edge_mag(win[1], win[2], win[2]);
        emit = 1'b1;
        last = (y == h + 1);
      end
      win[0] = c;
      win[1] = c;
      win[2] = c;
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = c;
      if (y >= 1) begin
        mag = edge_mag(win[0], win[1], win[2]);
        emit = 1'b1;
      end
    end
    col_n = x + 1;
    if (col_n >= w) begin
      col_n = 0;
      row_n = y + 1;
    end
    if (flush) begin
      owed--;
      if (owed == 0) clear_frame();
    end else if (col_n == 0 && row_n == h) begin
      owed = w + 1;
    end
    if (emit) begin
      e.edge_val = (mag < prior) ? mag[PixW-1:0] : prior;
      e.frame_end = last;
      edge_q.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_word_t e;
    if (!rst_ni) begin
      width_reg = CfgW'(ResetWidth);
      height_reg = CfgW'(ResetHeight);
      for (int i = 0; i < LineLen; i++) begin
        line_up[i] = '0;
        line_mid[i] = '0;
      end
      win[0] = '0;
      win[1] = '0;
      win[2] = '0;
      clear_frame();
      edge_q.delete();
      errs = 0;
      errors_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (edge_q.size() == 0) begin
          errs++;
          $display("%t unexpected word: edge_value %0d frame_end %0b", $time,
                   edge_value_o, frame_end_o);
        end else begin
          e = edge_q.pop_front();
          if (edge_value_o !== e.edge_val) begin
            errs++;
            $display("%t edge_value expected %0d actual %0d", $time, e.edge_val,
                     edge_value_o);
          end
          if (frame_end_o !== e.frame_end) begin
            errs++;
            $display("%t frame_end expected %0b actual %0b", $time, e.frame_end,
                     frame_end_o);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_FRAME_WIDTH) begin
          width_reg = cfg_data_i;
          clear_frame();
        end else if (cfg_index_i == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data_i;
          clear_frame();
        end
      end
      if (in_valid_i && !in_stall_o) predict_word(op_i, pixel_i, prior_value_i);
      errors_o <= errs;
      outstanding_o <= edge_q.size();
    end
  end

endmodule

@@ tb/sv/tb_sobel_edge_magnitude_top.sv @@
// Testbench top for sobel_edge_magnitude_top: drives frames, flush words and config
// writes under random idling; sem_edge_checker does the prediction and compare.
// Depends on sem_pkg, sem_edge_checker and the block.
`timescale 1ns / 100ps
module tb_sobel_edge_magnitude_top;
  import sem_pkg::*;

  localparam int CycleLimit = 1000000;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o, op_i;
  logic [PixW-1:0]    pixel_i, prior_value_i, edge_value_o;
  logic               out_valid_o, out_stall_i, frame_end_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  int                 errors, outstanding, cycles, sent_words;
  int                 send_idle_pct, recv_idle_pct, cur_w, cur_h;
  logic               hold_off;

  sobel_edge_magnitude_top dut (.*);

  sem_edge_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .pixel_i, .prior_value_i,
    .out_valid_o, .out_stall_i, .edge_value_o, .frame_end_o, .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .errors_o(errors), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_sobel_edge_magnitude_top: errors");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off while words keep coming
  initial begin
    hold_off = 1'b0;
    wait (sent_words >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic send_word(logic op, logic [PixW-1:0] pix, logic [PixW-1:0] prior);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    pixel_i <= pix;
    prior_value_i <= prior;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_words++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_frame(int w, int h);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i <= CfgW'(w);
    @(posedge clk_i);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i <= CfgW'(h);
    @(posedge clk_i);
    cfg_index_i <= CfgIdxW'($urandom_range(2, 15));
    cfg_data_i <= CfgW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_w = (w == 0) ? 1 : (w > MaxWidthDef) ? MaxWidthDef : w;
    cur_h = (h == 0) ? 1 : (h > HeightCap) ? HeightCap : h;
  endtask

  function automatic logic [PixW-1:0] pick_pixel(int kind, int i);
    case (kind)
      0: return 8'($urandom);
      1: return $urandom_range(1) ? 8'd255 : 8'd0;
      default: return 8'(i * 37 + $urandom_range(7));
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_prior();
    return ($urandom_range(9) < 7) ? 8'd255 : 8'($urandom);
  endfunction

  task automatic send_frame(int npix, int nflush);
    int kind;
    kind = $urandom_range(2);
    for (int i = 0; i < npix; i++) send_word(OP_PIXEL, pick_pixel(kind, i), pick_prior());
    for (int i = 0; i < nflush; i++) send_word(OP_FLUSH, 8'($urandom), pick_prior());
  endtask

  task automatic random_part(int target);
    int r, stop_at;
    stop_at = sent_words + target;
    while (sent_words < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        set_frame($urandom_range(1, 12), $urandom_range(1, 8));
      end else if (r < 12) begin
        send_word(OP_FLUSH, 8'($urandom), 8'($urandom));
      end else if (r < 25) begin
        send_frame($urandom_range(1, cur_w * cur_h), $urandom_range(0, cur_w));
      end else begin
        send_frame(cur_w * cur_h, cur_w + 1);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_PIXEL;
    pixel_i = '0;
    prior_value_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    cycles = 0;
    sent_words = 0;
    send_idle_pct = 33;
    recv_idle_pct = 78;
    cur_w = ResetWidth;
    cur_h = ResetHeight;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tiny frames, stray flushes, early abandon, single line, zero sizes
    set_frame(1, 1);
    send_word(OP_PIXEL, 8'd255, 8'd255);
    send_word(OP_FLUSH, 8'd0, 8'd255);
    send_word(OP_FLUSH, 8'd255, 8'd255);
    send_word(OP_FLUSH, 8'd0, 8'd0);
    set_frame(3, 2);
    send_word(OP_PIXEL, 8'd0, 8'd0);
    send_word(OP_PIXEL, 8'd255, 8'd255);
    send_word(OP_PIXEL, 8'd0, 8'd255);
    send_word(OP_PIXEL, 8'd255, 8'd255);
    send_word(OP_PIXEL, 8'd0, 8'd255);
    send_word(OP_PIXEL, 8'd255, 8'd128);
    send_word(OP_FLUSH, 8'd0, 8'd255);
    send_word(OP_FLUSH, 8'd0, 8'd255);
    send_frame(6, 4);
    set_frame(4, 1);
    send_frame(4, 5);
    set_frame(0, 0);
    send_frame(1, 2);

    random_part(500);
    drain();
    send_idle_pct = 78;
    recv_idle_pct = 33;
    random_part(500);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_part(500);

    // register values past the caps
    set_frame(4095, 3);
    send_frame(120, 0);
    set_frame(3, 4095);
    send_frame(60, 0);

    drain();
    if (errors == 0) begin
      $display("tb_sobel_edge_magnitude_top: clean");
    end else begin
      $display("tb_sobel_edge_magnitude_top: errors");
    end
    $finish;
  end

endmodule
